[rtl/rlec_pkg.sv]
package rlec_pkg;

    localparam int SINE_ENTRIES_DEF = 256;
    localparam int FADE_MS_DEF      = 500;
    localparam int REFRESH_MS_DEF   = 25;

    localparam int DIV_DW  = 40;
    localparam int DIV_SW  = 32;
    localparam int DIV_CW  = $clog2(DIV_DW + 1);
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [CFG_IW-1:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LUMINOSITY   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_LED_ENABLED  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_BLINK_ON     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BLINK_OFF    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PULSE_PERIOD = 3'd5;
    localparam logic [CFG_IW-1:0] REG_PWM_INVERTED = 3'd6;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_BLINK  = 2'd1;
    localparam logic [1:0] MODE_PULSE  = 2'd2;
    localparam logic [1:0] MODE_GLITCH = 2'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [31:0] GLITCH_MS = 32'd100;
    localparam logic [14:0] GLITCH_THRESH = 15'd17920;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       fade_request;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] red_duty;
        logic [7:0] green_duty;
        logic [7:0] blue_duty;
    } out_beat_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_SW-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_FADE_GO, S_FADE_WAIT, S_EFFECT,
        S_PMOD_GO, S_PMOD_WAIT, S_PIDX_GO, S_PIDX_WAIT, S_PSQR,
        S_PDIV_GO, S_PDIV_WAIT, S_PSCALE, S_DRAW, S_DRAW_USE, S_LUM
    } state_t;

endpackage

[rtl/rlec_div.sv]
module rlec_div
    import rlec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_SW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] quo_reg, quo_next;
    logic [DIV_SW-1:0] dsr_reg, dsr_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_SW:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_SW-1:0], quo_reg[DIV_DW-1]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[DIV_DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[DIV_SW-1:0];

endmodule

[rtl/rlec_lfsr.sv]
module rlec_lfsr
    import rlec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    output logic [7:0] rand_byte
);

    logic [15:0] lfsr_reg, lfsr_next;

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (step)
        begin
            lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 16'h0000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_SEED;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign rand_byte = lfsr_reg[7:0];

endmodule

[rtl/rgb_led_effect_pwm_controller.sv]
// A beat with no refresh goes from S_CHECK back to S_IDLE, freeing the input.
// A refresh beat passes S_CHECK, any fade, S_EFFECT, any pulse or draw steps
// and S_LUM, which waits for a free output. It uses bit-serial divisions
// (three for a fade, three for a pulse) and LFSR steps per byte drawn. One
// beat is in work at a time, and the 40-step divider sets the refresh time.
// Reset: time and the target, previous and glitch colours clear, registers take their defaults, seed 0xACE1.
module rgb_led_effect_pwm_controller
    import rlec_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int FADE_MS      = FADE_MS_DEF,
    parameter int REFRESH_MS   = REFRESH_MS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_beat_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_beat_t         out_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int KW = $clog2(SINE_ENTRIES) + 2;
    localparam int MW = 2 * KW;
    localparam logic [KW-1:0] N_K = KW'(SINE_ENTRIES);
    localparam logic [DIV_SW-1:0] DEN0 = DIV_SW'(5 * SINE_ENTRIES * SINE_ENTRIES);

    state_t state_reg, state_next;

    logic [1:0]  mode_reg;
    logic [8:0]  lum_reg;
    logic        en_reg;
    logic [7:0]  on_reg;
    logic [7:0]  off_reg;
    logic [15:0] period_reg;
    logic        inv_reg;

    logic [31:0] time_reg, last_reg, fstart_reg, mark_reg;
    logic [7:0]  tgt_reg [3];
    logic [7:0]  prev_reg [3];
    logic [7:0]  glc_reg [3];
    logic [7:0]  col_reg [3];
    logic        fade_act_reg, lit_reg;
    logic [15:0] e_reg;
    logic [1:0]  ch_reg;
    logic [15:0] ph_reg;
    logic [KW-1:0] k_reg;
    logic        neg_reg;
    logic [MW-1:0] m_reg;
    logic [8:0]  gain_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  draw_reg;
    logic        out_valid_reg;
    out_beat_t   out_reg;

    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        lfsr_step;
    logic [7:0]  rbyte;

    logic [31:0] since_ref, since_fade, since_mark;
    logic [15:0] p_eff;
    logic [7:0]  fa, fb, fdiff;
    logic [KW-1:0] k_raw;
    logic [DIV_SW-1:0] den;
    logic        out_free;
    logic [8:0]  lum_sat;
    logic [16:0] prod [3];
    logic [7:0]  duty [3];

    assign since_ref  = time_reg - last_reg;
    assign since_fade = time_reg - fstart_reg;
    assign since_mark = time_reg - mark_reg;
    assign p_eff      = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign fa         = prev_reg[ch_reg];
    assign fb         = tgt_reg[ch_reg];
    assign fdiff      = (fb >= fa) ? (fb - fa) : (fa - fb);
    assign k_raw      = {drsp.quotient[KW-2:0], 1'b0};
    assign den        = DEN0 - DIV_SW'({m_reg, 2'b00});
    assign out_free   = !out_valid_reg || out_ready;
    assign lum_sat    = lum_reg[8] ? 9'd256 : lum_reg;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign lfsr_step  = (state_reg == S_DRAW);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod[j] = 17'({9'd0, col_reg[j]} * lum_sat) + 17'd128;
            duty[j] = en_reg ? prod[j][15:8] : 8'd0;
            if (inv_reg)
            begin
                duty[j] = 8'd255 - duty[j];
            end
        end
    end

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = DIV_SW'(FADE_MS);
        unique case (state_reg)
            S_FADE_GO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_DW'(fdiff) * DIV_DW'(e_reg);
            end
            S_PMOD_GO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_DW'(time_reg);
                dreq.divisor  = DIV_SW'(p_eff);
            end
            S_PIDX_GO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_DW'(ph_reg) * DIV_DW'(SINE_ENTRIES);
                dreq.divisor  = DIV_SW'(p_eff);
            end
            S_PDIV_GO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = (DIV_DW'(m_reg) << 11) + DIV_DW'(den >> 1);
                dreq.divisor  = den;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (since_ref < 32'(REFRESH_MS))
                begin
                    state_next = S_IDLE;
                end
                else if (fade_act_reg && since_fade < 32'(FADE_MS))
                begin
                    state_next = S_FADE_GO;
                end
                else
                begin
                    state_next = S_EFFECT;
                end
            end
            S_FADE_GO:   state_next = S_FADE_WAIT;
            S_FADE_WAIT:
            begin
                if (drsp.done)
                begin
                    state_next = (ch_reg == 2'd2) ? S_EFFECT : S_FADE_GO;
                end
            end
            S_EFFECT:
            begin
                unique case (mode_reg)
                    MODE_PULSE:  state_next = S_PMOD_GO;
                    MODE_GLITCH: state_next = (since_mark > GLITCH_MS) ? S_DRAW : S_LUM;
                    default:     state_next = S_LUM;
                endcase
            end
            S_PMOD_GO:   state_next = S_PMOD_WAIT;
            S_PMOD_WAIT: state_next = drsp.done ? S_PIDX_GO : S_PMOD_WAIT;
            S_PIDX_GO:   state_next = S_PIDX_WAIT;
            S_PIDX_WAIT: state_next = drsp.done ? S_PSQR : S_PIDX_WAIT;
            S_PSQR:      state_next = S_PDIV_GO;
            S_PDIV_GO:   state_next = S_PDIV_WAIT;
            S_PDIV_WAIT: state_next = drsp.done ? S_PSCALE : S_PDIV_WAIT;
            S_PSCALE:    state_next = S_LUM;
            S_DRAW:      state_next = (cnt_reg == 3'd7) ? S_DRAW_USE : S_DRAW;
            S_DRAW_USE:
            begin
                if (draw_reg == 2'd0)
                begin
                    state_next = ((15'(rbyte) * 15'd100) < GLITCH_THRESH) ? S_DRAW : S_LUM;
                end
                else
                begin
                    state_next = (draw_reg == 2'd3) ? S_LUM : S_DRAW;
                end
            end
            S_LUM:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            lum_reg    <= 9'd256;
            en_reg     <= 1'b1;
            on_reg     <= 8'd0;
            off_reg    <= 8'd0;
            period_reg <= 16'd1000;
            inv_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:  mode_reg   <= cfg_data[1:0];
                REG_LUMINOSITY:   lum_reg    <= cfg_data[8:0];
                REG_LED_ENABLED:  en_reg     <= cfg_data[0];
                REG_BLINK_ON:     on_reg     <= cfg_data[7:0];
                REG_BLINK_OFF:    off_reg    <= cfg_data[7:0];
                REG_PULSE_PERIOD: period_reg <= cfg_data;
                REG_PWM_INVERTED: inv_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            last_reg      <= '0;
            fstart_reg    <= '0;
            mark_reg      <= '0;
            fade_act_reg  <= 1'b0;
            lit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            draw_reg      <= '0;
            for (int j = 0; j < 3; j++)
            begin
                tgt_reg[j]  <= '0;
                prev_reg[j] <= '0;
                glc_reg[j]  <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_LUM)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!in_data.req_type)
                        begin
                            time_reg <= time_reg + 32'd1;
                        end
                        else
                        begin
                            prev_reg     <= tgt_reg;
                            tgt_reg[0]   <= in_data.red_in;
                            tgt_reg[1]   <= in_data.green_in;
                            tgt_reg[2]   <= in_data.blue_in;
                            fade_act_reg <= in_data.fade_request;
                            fstart_reg   <= time_reg;
                        end
                    end
                end
                S_CHECK:
                begin
                    if (since_ref >= 32'(REFRESH_MS))
                    begin
                        last_reg <= time_reg;
                        col_reg  <= tgt_reg;
                        ch_reg   <= '0;
                        e_reg    <= since_fade[15:0];
                        if (fade_act_reg && since_fade >= 32'(FADE_MS))
                        begin
                            fade_act_reg <= 1'b0;
                        end
                    end
                end
                S_FADE_WAIT:
                begin
                    if (drsp.done)
                    begin
                        if (fb >= fa)
                        begin
                            col_reg[ch_reg] <= fa + drsp.quotient[7:0];
                        end
                        else
                        begin
                            col_reg[ch_reg] <= fa - drsp.quotient[7:0]
                                - {7'd0, (drsp.remainder != '0)};
                        end
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                S_EFFECT:
                begin
                    if (mode_reg == MODE_BLINK)
                    begin
                        if (since_mark < {24'd0, (lit_reg ? on_reg : off_reg)})
                        begin
                            if (!lit_reg)
                            begin
                                col_reg <= '{8'd0, 8'd0, 8'd0};
                            end
                        end
                        else
                        begin
                            lit_reg  <= !lit_reg;
                            mark_reg <= time_reg;
                        end
                    end
                    else if (mode_reg == MODE_GLITCH)
                    begin
                        if (since_mark > GLITCH_MS)
                        begin
                            mark_reg <= time_reg;
                            draw_reg <= '0;
                            cnt_reg  <= '0;
                        end
                        else
                        begin
                            col_reg <= glc_reg;
                        end
                    end
                end
                S_DRAW:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
                S_DRAW_USE:
                begin
                    if (draw_reg == 2'd0)
                    begin
                        if ((15'(rbyte) * 15'd100) < GLITCH_THRESH)
                        begin
                            draw_reg <= 2'd1;
                        end
                        else
                        begin
                            col_reg <= tgt_reg;
                            glc_reg <= tgt_reg;
                        end
                    end
                    else
                    begin
                        col_reg[draw_reg - 2'd1] <= rbyte;
                        draw_reg <= draw_reg + 2'd1;
                        if (draw_reg == 2'd3)
                        begin
                            glc_reg[0] <= col_reg[0];
                            glc_reg[1] <= col_reg[1];
                            glc_reg[2] <= rbyte;
                        end
                    end
                end
                S_PSCALE:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        col_reg[j] <= 8'(({9'd0, col_reg[j]} * {8'd0, gain_reg}) >> 8);
                    end
                end
                S_LUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PMOD_WAIT && drsp.done)
        begin
            ph_reg <= drsp.remainder[15:0];
        end
        if (state_reg == S_PIDX_WAIT && drsp.done)
        begin
            if (k_raw >= N_K)
            begin
                k_reg   <= k_raw - N_K;
                neg_reg <= 1'b1;
            end
            else
            begin
                k_reg   <= k_raw;
                neg_reg <= 1'b0;
            end
        end
        if (state_reg == S_PSQR)
        begin
            m_reg <= MW'(k_reg) * MW'(N_K - k_reg);
        end
        if (state_reg == S_PDIV_WAIT && drsp.done)
        begin
            gain_reg <= neg_reg ? (9'd128 - drsp.quotient[8:0])
                                : (9'd128 + drsp.quotient[8:0]);
        end
        if (state_reg == S_LUM && out_free)
        begin
            out_reg.red_duty   <= duty[0];
            out_reg.green_duty <= duty[1];
            out_reg.blue_duty  <= duty[2];
        end
    end

    rlec_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    rlec_lfsr u_lfsr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (lfsr_step),
        .rand_byte (rbyte)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a beat is in work");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_FADE_WAIT || state_reg == S_PMOD_WAIT ||
                       state_reg == S_PIDX_WAIT || state_reg == S_PDIV_WAIT))
        else $error("divider result with no waiting state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(out_reg))
        else $error("pending result overwritten");

endmodule
